// ===== hw/rtl/egc_pkg.sv =====
package egc_pkg;

  localparam int EGC_MAX_VERTICES = 128;

  localparam int VERTEX_W = 7;
  localparam int COUNT_W  = 8;
  localparam int CLASS_W  = 2;

  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 8'd128;
  localparam logic [COUNT_W-1:0] ODD_SAT            = 8'hFF;
  localparam logic [COUNT_W-1:0] ODD_PAIR           = 8'd2;

  localparam logic [CLASS_W-1:0] CLS_NOT_CONN = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_EULER    = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_SEMI     = 2'd2;
  localparam logic [CLASS_W-1:0] CLS_NEITHER  = 2'd3;

  typedef logic [VERTEX_W-1:0] vertex_t;

  // status of the odd-degree counter
  typedef struct packed {
    logic               done;
    logic [COUNT_W-1:0] odd;
  } odd_stat_t;

endpackage

// ===== hw/rtl/egc_edge_if.sv =====
interface egc_edge_if;
  import egc_pkg::*;

  logic    valid;
  logic    ready;
  vertex_t first_vertex;
  vertex_t second_vertex;
  logic    last_edge;

  modport source (output valid, first_vertex, second_vertex, last_edge, input ready);
  modport sink   (input valid, first_vertex, second_vertex, last_edge, output ready);
endinterface

// ===== hw/rtl/egc_class_if.sv =====
interface egc_class_if;
  import egc_pkg::*;

  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] graph_class;
  logic [COUNT_W-1:0] odd_vertex_count;

  modport source (output valid, graph_class, odd_vertex_count, input ready);
  modport sink   (input valid, graph_class, odd_vertex_count, output ready);
endinterface

// ===== hw/rtl/egc_ram.sv =====
module egc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/egc_first_set.sv =====
module egc_first_set #(
  parameter int N  = 2,
  parameter int IW = (N > 1) ? $clog2(N) : 1
) (
  input  logic [N-1:0]  vec,
  output logic          any,
  output logic [N-1:0]  onehot,
  output logic [IW-1:0] idx
);

  // lowest set bit by two's complement isolate
  assign onehot = vec & (~vec + N'(1));
  assign any    = |vec;

  always_comb begin
    idx = '0;
    for (int i = 0; i < N; i++) begin
      if (onehot[i]) begin
        idx = idx | IW'(i);
      end
    end
  end

endmodule

// ===== hw/rtl/egc_odd_count.sv =====
module egc_odd_count #(
  parameter int N = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [N-1:0]      vec,
  output egc_pkg::odd_stat_t stat
);
  import egc_pkg::*;

  logic               busy;
  logic [N-1:0]       sh;
  logic [COUNT_W-1:0] odd;

  // one bit per cycle, stops once the remaining bits are all zero
  // start is only taken while idle, so a held start does not reload
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start && !busy) begin
      busy <= 1'b1;
      sh   <= vec;
      odd  <= '0;
    end else if (busy) begin
      if (sh == '0) begin
        busy <= 1'b0;
      end else begin
        sh <= sh >> 1;
        if (sh[0] && odd != ODD_SAT) begin
          odd <= odd + COUNT_W'(1);
        end
      end
    end
  end

  assign stat.done = busy && (sh == '0);
  assign stat.odd  = odd;

endmodule

// ===== hw/rtl/euler_graph_classifier.sv =====
// channel   dir  word                                        handshake
// edges     in   first_vertex, second_vertex, last_edge      valid / ready
// result    out  graph_class, odd_vertex_count                valid / ready
// cfg       in   cfg_data (vertex_count)                     cfg_we, no wait
//
// an edge reads its first row while idle, then S_WRU and S_WRV write both adjacency
// rows; an edge with an endpoint out of range writes nothing.
// a final edge adds the walk: a pick and a merge step per reached vertex through the
// single adjacency memory port, then the parity count.
// rst is synchronous; touched bits serve as row valid bits, so no memory sweep.
// a finished result waits in the output register; a further final edge stalls
// only until that word is taken.
module euler_graph_classifier #(
  parameter int MAX_VERTICES = egc_pkg::EGC_MAX_VERTICES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [egc_pkg::COUNT_W-1:0] cfg_data,
  egc_edge_if.sink                    edges,
  egc_class_if.source                 result
);
  import egc_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = (VW > VERTEX_W) ? VW : VERTEX_W;
  localparam logic [MAX_VERTICES-1:0] ONE = MAX_VERTICES'(1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRU   = 3'd1;
  localparam logic [2:0] S_WRV   = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_PICK  = 3'd4;
  localparam logic [2:0] S_MERGE = 3'd5;
  localparam logic [2:0] S_CHECK = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]              state;
  logic [COUNT_W-1:0]      vertex_count;
  logic [VW-1:0]           eu, ev;
  logic                    elast;
  logic [MAX_VERTICES-1:0] touched, parity, reached, pending;
  logic [CLASS_W-1:0]      res_class, out_class;
  logic [COUNT_W-1:0]      res_odd, out_odd;
  logic                    out_valid;

  logic                    accept;
  logic [CW-1:0]           in_u_ext, in_v_ext;
  logic                    in_ok;
  logic [MAX_VERTICES-1:0] u_hot, v_hot, lim_mask, old_row;
  logic                    disconnected;

  logic                    ram_we;
  logic [VW-1:0]           ram_waddr, ram_raddr;
  logic [MAX_VERTICES-1:0] ram_wdata, ram_rdata;

  logic [MAX_VERTICES-1:0] fs_vec, fs_hot;
  logic                    fs_any;
  logic [VW-1:0]           fs_idx;

  logic                    cnt_start;
  odd_stat_t               cnt_stat;

  assign edges.ready = (state == S_IDLE);
  assign accept      = edges.valid && edges.ready;

  assign in_u_ext = CW'(edges.first_vertex);
  assign in_v_ext = CW'(edges.second_vertex);
  assign in_ok    = (32'(edges.first_vertex) < MAX_VERTICES) &&
                    (32'(edges.second_vertex) < MAX_VERTICES);

  assign u_hot = ONE << eu;
  assign v_hot = ONE << ev;

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      lim_mask[i] = (i < int'(vertex_count));
    end
  end

  assign disconnected = |(touched & lim_mask & ~reached);

  // adjacency row port
  always_comb begin
    case (state)
      S_IDLE:  ram_raddr = in_u_ext[VW-1:0];
      S_WRU:   ram_raddr = ev;
      default: ram_raddr = fs_idx;
    endcase
  end

  assign ram_we    = (state == S_WRU) || ((state == S_WRV) && (eu != ev));
  assign ram_waddr = (state == S_WRU) ? eu : ev;
  // a row not yet touched in this graph reads as empty
  assign old_row   = ram_rdata & {MAX_VERTICES{touched[ram_waddr]}};
  assign ram_wdata = old_row | ((state == S_WRU) ? v_hot : u_hot);

  egc_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES),
    .AW    (VW)
  ) u_adj (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared lowest-bit finder: start vertex, then next pending vertex
  assign fs_vec = (state == S_START) ? (touched & lim_mask) : pending;

  egc_first_set #(
    .N  (MAX_VERTICES),
    .IW (VW)
  ) u_first (
    .vec    (fs_vec),
    .any    (fs_any),
    .onehot (fs_hot),
    .idx    (fs_idx)
  );

  assign cnt_start = (state == S_CHECK) && !disconnected;

  egc_odd_count #(
    .N (MAX_VERTICES)
  ) u_odd (
    .clk   (clk),
    .rst   (rst),
    .start (cnt_start),
    .vec   (parity & lim_mask),
    .stat  (cnt_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= VERTEX_COUNT_RESET;
      touched      <= '0;
      parity       <= '0;
      reached      <= '0;
      pending      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        vertex_count <= cfg_data;
      end
      if (out_valid && result.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            eu    <= in_u_ext[VW-1:0];
            ev    <= in_v_ext[VW-1:0];
            elast <= edges.last_edge;
            if (in_ok) begin
              state <= S_WRU;
            end else if (edges.last_edge) begin
              state <= S_START;
            end
          end
        end
        S_WRU: begin
          state <= S_WRV;
        end
        S_WRV: begin
          touched <= touched | u_hot | v_hot;
          parity  <= parity ^ u_hot ^ v_hot;
          state   <= elast ? S_START : S_IDLE;
        end
        S_START: begin
          if (fs_any) begin
            reached <= fs_hot;
            pending <= fs_hot;
            state   <= S_PICK;
          end else begin
            state <= S_CHECK;
          end
        end
        S_PICK: begin
          if (fs_any) begin
            pending <= pending & ~fs_hot;
            state   <= S_MERGE;
          end else begin
            state <= S_CHECK;
          end
        end
        S_MERGE: begin
          reached <= reached | ram_rdata;
          pending <= pending | (ram_rdata & ~reached);
          state   <= S_PICK;
        end
        S_CHECK: begin
          if (disconnected) begin
            res_class <= CLS_NOT_CONN;
            res_odd   <= '0;
            state     <= S_DONE;
          end else if (cnt_stat.done) begin
            res_odd <= cnt_stat.odd;
            if (cnt_stat.odd == '0) begin
              res_class <= CLS_EULER;
            end else if (cnt_stat.odd == ODD_PAIR) begin
              res_class <= CLS_SEMI;
            end else begin
              res_class <= CLS_NEITHER;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_class <= res_class;
            out_odd   <= res_odd;
            touched   <= '0;
            parity    <= '0;
            reached   <= '0;
            pending   <= '0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid            = out_valid;
  assign result.graph_class      = out_class;
  assign result.odd_vertex_count = out_odd;

  // the walk only ever reaches vertices of the current graph
  a_reached_touched: assert property (@(posedge clk) disable iff (rst)
    (reached & ~touched) == '0)
    else $error("reached vertex outside touched set");

  a_pending_reached: assert property (@(posedge clk) disable iff (rst)
    (pending & ~reached) == '0)
    else $error("pending vertex not marked reached");

  a_word_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result word raised outside done state");

  a_class_odd: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_class == CLS_NOT_CONN || out_class == CLS_EULER) |->
    out_odd == '0)
    else $error("odd count disagrees with class");

  a_cleared: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && $past(state) == S_DONE |-> touched == '0 && parity == '0)
    else $error("stores not cleared after graph");

endmodule
